>>> sv/sdl_pkg.sv
// Package for the sorted directory lookup block.
// Holds sizes, command codes, the controller/datapath bundles and key helpers.
// No dependencies.
`timescale 1ns / 1ps
package sdl_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int POS_W = CNT_W + 2;
	localparam int KEY_W = 72;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_BUILD  = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_RSVD     = 2'd3
	} status_code_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic add_exec;
		logic bld_init;
		logic bld_key_rd;
		logic bld_key_cap;
		logic bld_probe_rd;
		logic name_rd;
		logic bld_cmp;
		logic shift_init;
		logic shr_rd;
		logic shw;
		logic ins;
		logic bld_fin;
		logic lk_probe_rd;
		logic lk_cmp;
		logic lk_miss;
		logic emit;
	} sdl_cmd_t;

	typedef struct packed {
		logic      in_valid;
		cmd_code_t in_cmd;
		logic      i_end;
		logic      lo_lt_hi;
		logic      j_gt_lo;
		logic      cmp_eq;
		logic      count_zero;
		logic      out_free;
	} sdl_sts_t;

	// Zero every byte after the first NUL and optionally uppercase a-z.
	function automatic logic [63:0] norm_name(input logic [63:0] v, input logic upper);
		logic [63:0] r;
		logic        live;
		logic [7:0]  c;
		r = '0;
		live = 1'b1;
		for (int b = 0; b < 8; b++) begin
			c = v[8*b +: 8];
			if (c == 8'h00) begin
				live = 1'b0;
			end
			if (upper && c >= 8'h61 && c <= 8'h7A) begin
				c = c - 8'h20;
			end
			if (live) begin
				r[8*b +: 8] = c;
			end
		end
		return r;
	endfunction

	// Unsigned ordering value: signed word0, then signed word1, then namespace.
	function automatic logic [KEY_W-1:0] key_ord(input logic [63:0] n, input logic [7:0] sp);
		return {~n[31], n[30:0], ~n[63], n[62:32], sp};
	endfunction

endpackage

>>> sv/sdl_ifs.sv
// Valid/ready channel interfaces for the sorted directory lookup block.
// Depends on nothing.
`timescale 1ns / 1ps
interface sdl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] entry_name;
	logic [7:0]  name_space;
	modport source (output valid, cmd, entry_name, name_space, input ready);
	modport sink (input valid, cmd, entry_name, name_space, output ready);
endinterface

interface sdl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] entry_index;
	logic [12:0] unique_total;
	modport source (output valid, status, entry_index, unique_total, input ready);
	modport sink (input valid, status, entry_index, unique_total, output ready);
endinterface

>>> sv/sdl_ctrl.sv
// Controller state machine of the sorted directory lookup block.
// Depends on sdl_pkg; drives the datapath through sdl_cmd_t.
`timescale 1ns / 1ps
module sdl_ctrl
	import sdl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  sdl_sts_t sts,
	output sdl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_BNEXT, S_BKEY, S_BPROBE, S_BIDX, S_BCMP,
		S_SHR, S_SHW, S_LPROBE, S_LIDX, S_LCMP, S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					case (sts.in_cmd)
						CMD_ADD:    state_d = S_ADD;
						CMD_BUILD: begin
							cmd.bld_init = 1'b1;
							state_d = S_BNEXT;
						end
						CMD_LOOKUP: state_d = S_LPROBE;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_ADD: begin
				cmd.add_exec = 1'b1;
				state_d = S_DONE;
			end
			S_BNEXT: begin
				if (sts.i_end) begin
					cmd.bld_fin = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.bld_key_rd = 1'b1;
					state_d = S_BKEY;
				end
			end
			S_BKEY: begin
				cmd.bld_key_cap = 1'b1;
				state_d = S_BPROBE;
			end
			S_BPROBE: begin
				if (sts.lo_lt_hi) begin
					cmd.bld_probe_rd = 1'b1;
					state_d = S_BIDX;
				end else begin
					cmd.shift_init = 1'b1;
					state_d = S_SHR;
				end
			end
			S_BIDX: begin
				cmd.name_rd = 1'b1;
				state_d = S_BCMP;
			end
			S_BCMP: begin
				cmd.bld_cmp = 1'b1;
				state_d = sts.cmp_eq ? S_BNEXT : S_BPROBE;
			end
			S_SHR: begin
				if (sts.j_gt_lo) begin
					cmd.shr_rd = 1'b1;
					state_d = S_SHW;
				end else begin
					cmd.ins = 1'b1;
					state_d = S_BNEXT;
				end
			end
			S_SHW: begin
				cmd.shw = 1'b1;
				state_d = S_SHR;
			end
			S_LPROBE: begin
				if (sts.count_zero) begin
					cmd.lk_miss = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.lk_probe_rd = 1'b1;
					state_d = S_LIDX;
				end
			end
			S_LIDX: begin
				cmd.name_rd = 1'b1;
				state_d = S_LCMP;
			end
			S_LCMP: begin
				cmd.lk_cmp = 1'b1;
				state_d = sts.cmp_eq ? S_DONE : S_LPROBE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/sdl_dpath.sv
// Datapath of the sorted directory lookup block: entry and index memories,
// search registers, key compare and the result register. Depends on sdl_pkg.
`timescale 1ns / 1ps
module sdl_dpath
	import sdl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	sdl_in_if.sink   in_ch,
	sdl_out_if.source out_ch,
	input  sdl_cmd_t cmd,
	output sdl_sts_t sts
);

	logic [63:0]      names_mem [MAX_ENTRIES];
	logic [7:0]       spaces_mem [MAX_ENTRIES];
	logic [IDX_W-1:0] sorted_mem [MAX_ENTRIES];

	logic [63:0]      names_rd_q;
	logic [7:0]       spaces_rd_q;
	logic [IDX_W-1:0] sorted_rd_q;

	logic [CNT_W-1:0] entry_total_q;
	logic [CNT_W-1:0] sorted_total_q;
	logic [CNT_W-1:0] i_q, u_q, lo_q, hi_q, j_q;
	logic [IDX_W-1:0] mid_q, idx_q;
	logic [63:0]      key_name_q;
	logic [7:0]       key_sp_q;
	logic signed [POS_W-1:0] pos_q, step_q;
	logic [CNT_W:0]   count_q;
	logic [1:0]       res_status_q;
	logic [IDX_W-1:0] res_index_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [IDX_W-1:0] out_index_q;
	logic [CNT_W-1:0] out_unique_q;

	logic [KEY_W-1:0] key_a, key_b;
	logic             cmp_lt;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] names_raddr, sorted_raddr, sorted_waddr, sorted_wdata;
	logic             sorted_we;
	logic [CNT_W-1:0] j_dec;
	logic signed [POS_W-1:0] n_s, p0, pos_dn, pos_up;
	logic [63:0]      in_norm;

	assign key_a = key_ord(key_name_q, key_sp_q);
	assign key_b = key_ord(names_rd_q, spaces_rd_q);
	assign cmp_lt = key_a < key_b;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign j_dec = j_q - CNT_W'(1);
	assign n_s = POS_W'(signed'({2'b00, sorted_total_q}));
	assign p0 = (n_s + POS_W'(1)) >>> 1;
	assign pos_dn = pos_q - step_q;
	assign pos_up = pos_q + step_q;
	assign in_norm = norm_name(in_ch.entry_name, in_ch.cmd == CMD_LOOKUP);

	always_comb begin
		sts.in_valid = in_ch.valid;
		sts.in_cmd = cmd_code_t'(in_ch.cmd);
		sts.i_end = i_q == entry_total_q;
		sts.lo_lt_hi = lo_q < hi_q;
		sts.j_gt_lo = j_q > lo_q;
		sts.cmp_eq = key_a == key_b;
		sts.count_zero = count_q == '0;
		sts.out_free = !out_valid_q || out_ch.ready;
	end

	always_comb begin
		names_raddr = cmd.bld_key_rd ? i_q[IDX_W-1:0] : sorted_rd_q;
		if (cmd.shr_rd) begin
			sorted_raddr = j_dec[IDX_W-1:0];
		end else if (cmd.bld_probe_rd) begin
			sorted_raddr = mid_sum[IDX_W:1];
		end else begin
			sorted_raddr = pos_q[IDX_W-1:0];
		end
		sorted_we = cmd.shw || cmd.ins || (cmd.bld_cmp && sts.cmp_eq);
		sorted_waddr = cmd.shw ? j_q[IDX_W-1:0] : (cmd.ins ? lo_q[IDX_W-1:0] : mid_q);
		sorted_wdata = cmd.shw ? sorted_rd_q : i_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_exec && entry_total_q < CNT_W'(MAX_ENTRIES)) begin
			names_mem[entry_total_q[IDX_W-1:0]] <= key_name_q;
			spaces_mem[entry_total_q[IDX_W-1:0]] <= key_sp_q;
		end
		names_rd_q <= names_mem[names_raddr];
		spaces_rd_q <= spaces_mem[names_raddr];
		if (sorted_we) begin
			sorted_mem[sorted_waddr] <= sorted_wdata;
		end
		sorted_rd_q <= sorted_mem[sorted_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_name_q <= in_norm;
			key_sp_q <= in_ch.name_space;
			res_status_q <= ST_OK;
			res_index_q <= '0;
			step_q <= (p0 + POS_W'(1)) >>> 1;
			count_q <= {p0[CNT_W-1:0], 1'b0};
			if (n_s > POS_W'(0) && p0 > n_s - POS_W'(1)) begin
				pos_q <= n_s - POS_W'(1);
			end else begin
				pos_q <= p0;
			end
		end
		if (cmd.add_exec) begin
			if (entry_total_q < CNT_W'(MAX_ENTRIES)) begin
				res_index_q <= entry_total_q[IDX_W-1:0];
			end else begin
				res_status_q <= ST_FULL;
			end
		end
		if (cmd.bld_key_rd) begin
			lo_q <= '0;
			hi_q <= u_q;
		end
		if (cmd.bld_key_cap) begin
			key_name_q <= names_rd_q;
			key_sp_q <= spaces_rd_q;
		end
		if (cmd.bld_probe_rd) begin
			mid_q <= mid_sum[IDX_W:1];
		end
		if (cmd.name_rd) begin
			idx_q <= sorted_rd_q;
		end
		if (cmd.bld_cmp && !sts.cmp_eq) begin
			if (cmp_lt) begin
				hi_q <= {1'b0, mid_q};
			end else begin
				lo_q <= {1'b0, mid_q} + CNT_W'(1);
			end
		end
		if (cmd.shift_init) begin
			j_q <= u_q;
		end
		if (cmd.shw) begin
			j_q <= j_dec;
		end
		if (cmd.lk_cmp) begin
			if (sts.cmp_eq) begin
				res_index_q <= idx_q;
			end else begin
				if (cmp_lt) begin
					pos_q <= (pos_dn < POS_W'(0)) ? POS_W'(0) : pos_dn;
				end else begin
					pos_q <= (pos_up >= n_s) ? n_s - POS_W'(1) : pos_up;
				end
				step_q <= (step_q + POS_W'(1)) >>> 1;
				count_q <= count_q >> 1;
			end
		end
		if (cmd.lk_miss) begin
			res_status_q <= ST_NOTFOUND;
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_index_q <= res_index_q;
			out_unique_q <= sorted_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total_q <= '0;
			sorted_total_q <= '0;
			i_q <= '0;
			u_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.add_exec) begin
				sorted_total_q <= '0;
				if (entry_total_q < CNT_W'(MAX_ENTRIES)) begin
					entry_total_q <= entry_total_q + CNT_W'(1);
				end
			end
			if (cmd.bld_init) begin
				i_q <= '0;
				u_q <= '0;
			end
			if ((cmd.bld_cmp && sts.cmp_eq) || cmd.ins) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (cmd.ins) begin
				u_q <= u_q + CNT_W'(1);
			end
			if (cmd.bld_fin) begin
				sorted_total_q <= u_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ch.ready = cmd.in_ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.status = out_status_q;
	assign out_ch.entry_index = out_index_q;
	assign out_ch.unique_total = out_unique_q;

endmodule

>>> sv/sorted_directory_lookup.sv
// Sorted directory lookup: a directory of 8-byte names with namespaces,
// a sorted de-duplicated index built on request, and binary-search lookups.
// Input channel in_ch carries cmd, entry_name and name_space; a beat is taken
// only while the block is idle. Output channel out_ch returns one beat per
// input beat with status, entry_index and unique_total.
// A lookup makes at most 13 table probes for 4096 sorted entries; each probe
// reads the index memory, then the entry memory, through their single read
// ports one after another, and then compares the keys.
// A build reads each stored entry and binary-searches the index for its key,
// with the same read-then-compare steps; a new key is inserted by moving
// index slots one at a time to make room, so the build time grows with the
// square of the entry count in the worst case.
// The result waits in an output register; while the receiver stalls the
// block finishes the item it holds and then stops before taking the next.
// Reset empties the directory and the sorted index at once; memory contents
// are left as they are and are only read after being written.
`timescale 1ns / 1ps
module sorted_directory_lookup
	import sdl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sdl_in_if.sink    in_ch,
	sdl_out_if.source out_ch
);

	sdl_cmd_t cmd;
	sdl_sts_t sts;

	sdl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sdl_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.sts    (sts)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input beat taken while an item is in progress");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result written over an undelivered beat");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_ch.valid)
		else $error("result not presented after emit");
	a_load_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_ch.valid && in_ch.ready))
		else $error("input captured without a beat");
`endif

endmodule
